@@ rtl/core/dblg_pkg.sv @@
// Shared types and constants for the double-buffered level grid.
// Used by dblg_ctrl, dblg_datapath and double_buffered_level_grid; no dependencies.
package dblg_pkg;

   // Default grid size limits, handed to the top-level parameters.
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 64;

   // Field widths fixed by the item format.
   localparam int OP_W    = 4;
   localparam int COORD_W = 16;
   localparam int BYTE_W  = 8;
   localparam int GRID_W  = 7;
   localparam int TOTAL_W = 20;
   localparam int COUNT_W = 13;

   // Stream word widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;
   localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

   // Cell arithmetic constants.
   localparam logic [BYTE_W-1:0] LEVEL_MAX   = 8'd255;
   localparam logic [BYTE_W-1:0] TOXIC_LEVEL = 8'd128;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SET       = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD       = 4'd1;
   localparam logic [OP_W-1:0] OP_DECAY     = 4'd2;
   localparam logic [OP_W-1:0] OP_READ_CUR  = 4'd3;
   localparam logic [OP_W-1:0] OP_READ_PREV = 4'd4;
   localparam logic [OP_W-1:0] OP_SWAP      = 4'd5;
   localparam logic [OP_W-1:0] OP_STATS     = 4'd6;
   localparam logic [OP_W-1:0] OP_THRESH    = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;        // capture the accepted request word
      logic calc;         // register range check, cell address and cell count
      logic rd_cell;      // read both banks at the cell address
      logic wr_cell;      // write back the modified cell (gated by range and opcode)
      logic swap;         // toggle the current bank
      logic acc_clear;    // clear the scan accumulators
      logic cnt_clear;    // clear the sweep counter
      logic cnt_inc;      // advance the sweep counter
      logic rd_scan;      // read the current bank at the sweep counter
      logic clear_wr;     // write zero to both banks at the sweep counter
      logic stat_zero;    // zero the held statistics
      logic stat_commit;  // copy scan results into the held statistics (stats only)
      logic out_load;     // load the result register
   } dblg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;   // opcode of the item in progress
      logic scan_end;        // sweep counter has reached the cell count in use
      logic sweep_last;      // sweep counter is at the last word of a bank
      logic out_free;        // result register can take a word this cycle
   } dblg_sts_type;

endpackage

@@ rtl/core/dblg_ctrl.sv @@
// Controller state machine for the double-buffered level grid.
// Depends on dblg_pkg for the command and status structs and the opcodes.
module dblg_ctrl
   import dblg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dblg_sts_type sts,
   output dblg_cmd_type cmd
);

   typedef enum logic [7:0] {
      S_INIT_CLR = 8'b0000_0001,
      S_IDLE     = 8'b0000_0010,
      S_CALC     = 8'b0000_0100,
      S_READ     = 8'b0000_1000,
      S_MODIFY   = 8'b0001_0000,
      S_SCAN     = 8'b0010_0000,
      S_CLEAR    = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         S_INIT_CLR: begin
            cmd.clear_wr = 1'b1;
            if (sts.sweep_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc      = 1'b1;
            cmd.cnt_clear = 1'b1;
            cmd.acc_clear = 1'b1;
            unique case (sts.op) inside
               OP_SET, OP_ADD, OP_DECAY, OP_READ_CUR, OP_READ_PREV: begin
                  state_in = S_READ;
               end
               OP_SWAP: begin
                  cmd.swap = 1'b1;
                  state_in = S_DONE;
               end
               OP_STATS, OP_THRESH: begin
                  state_in = S_SCAN;
               end
               OP_CLEAR: begin
                  state_in = S_CLEAR;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            cmd.rd_cell = 1'b1;
            state_in    = S_MODIFY;
         end
         S_MODIFY: begin
            cmd.wr_cell = 1'b1;
            state_in    = S_DONE;
         end
         S_SCAN: begin
            if (sts.scan_end) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_scan = 1'b1;
               cmd.cnt_inc = 1'b1;
            end
         end
         S_CLEAR: begin
            cmd.clear_wr  = 1'b1;
            cmd.stat_zero = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_DONE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_DONE: begin
            cmd.stat_commit = 1'b1;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset) cmd.out_load |-> sts.out_free)
      else $error("result loaded into a full output register");

   // Only one item is in flight: after an accept the request side closes.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in progress");

   // The scan never reads past the cell count in use.
   assert property (@(posedge clock) disable iff (reset) cmd.rd_scan |-> !sts.scan_end)
      else $error("scan read issued past the end of the grid");

endmodule

@@ rtl/core/dblg_datapath.sv @@
// Datapath of the double-buffered level grid: both cell banks, address math,
// cell update, scan accumulators, held statistics and the result register.
// Depends on dblg_pkg for widths, constants and the command and status structs.
module dblg_datapath
   import dblg_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_op,
   input  logic [COORD_W-1:0]  req_col,
   input  logic [COORD_W-1:0]  req_row,
   input  logic [BYTE_W-1:0]   req_value,
   input  logic [BYTE_W-1:0]   req_kind,
   input  logic [GRID_W-1:0]   grid_width,
   input  logic [GRID_W-1:0]   grid_height,
   input  dblg_cmd_type        cmd,
   output dblg_sts_type        sts,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [BYTE_W-1:0]   rsp_level,
   output logic [BYTE_W-1:0]   rsp_kind,
   output logic                rsp_in_range,
   output logic [TOTAL_W-1:0]  rsp_total,
   output logic [COUNT_W-1:0]  rsp_count
);

   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam int EWC   = $clog2(MAX_COLS + 1);
   localparam int EWR   = $clog2(MAX_ROWS + 1);
   localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int PW    = RIW + EWC + 1;
   localparam int WORD_W = 2 * BYTE_W;

   // Latched request fields.
   logic [OP_W-1:0]    op_ff;
   logic [COORD_W-1:0] col_ff, row_ff;
   logic [BYTE_W-1:0]  val_ff, kind_ff;

   // Address stage.
   logic [EWC-1:0]   eff_w;
   logic [EWR-1:0]   eff_h;
   logic             inside_in, inside_ff;
   logic [PW-1:0]    idx_full;
   logic [AW-1:0]    idx_ff;
   logic [CNT_W-1:0] ncells_ff;

   // Sweep counter, shared by scans and clearing passes.
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Banks and their registered read data.
   logic [WORD_W-1:0] mem_a [CELLS];
   logic [WORD_W-1:0] mem_b [CELLS];
   logic [WORD_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              rd_en, we_a, we_b;
   logic [WORD_W-1:0] wr_data;
   logic              bank_sel_ff;
   logic [WORD_W-1:0] cur_word, prev_word;

   // Cell update.
   logic [BYTE_W-1:0] cur_lv, cur_ty, new_lv, new_ty;
   logic [BYTE_W:0]   add_sum;
   logic              cell_we;

   // Scan accumulators and held statistics.
   logic               scan_pend_ff;
   logic [TOTAL_W-1:0] acc_sum_ff;
   logic [COUNT_W-1:0] acc_cnt_ff;
   logic [BYTE_W-1:0]  thresh;
   logic [TOTAL_W-1:0] stat_total_ff;
   logic [COUNT_W-1:0] stat_toxic_ff;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_level_ff, out_kind_ff;
   logic               out_range_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic [BYTE_W-1:0]  res_level, res_kind;
   logic               res_range;
   logic [TOTAL_W-1:0] res_total;
   logic [COUNT_W-1:0] res_count;
   logic               is_read;

   // Register values above the grid limit act as the limit.
   always_comb begin
      if (32'(grid_width) > MAX_COLS) begin
         eff_w = EWC'(MAX_COLS);
      end else begin
         eff_w = EWC'(grid_width);
      end
      if (32'(grid_height) > MAX_ROWS) begin
         eff_h = EWR'(MAX_ROWS);
      end else begin
         eff_h = EWR'(grid_height);
      end
   end

   assign inside_in = !col_ff[COORD_W-1] && !row_ff[COORD_W-1]
                   && (col_ff < COORD_W'(eff_w)) && (row_ff < COORD_W'(eff_h));
   assign idx_full  = PW'(row_ff[RIW-1:0]) * PW'(eff_w) + PW'(col_ff[CIW-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_op;
         col_ff  <= req_col;
         row_ff  <= req_row;
         val_ff  <= req_value;
         kind_ff <= req_kind;
      end
      if (cmd.calc) begin
         inside_ff <= inside_in;
         idx_ff    <= AW'(idx_full);
         ncells_ff <= CNT_W'(eff_w * eff_h);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Memory ports: the sweep counter addresses scans and clears, the
   // registered cell address everything else.
   assign rd_en   = cmd.rd_cell || cmd.rd_scan;
   assign rd_addr = cmd.rd_scan ? cnt_ff[AW-1:0] : idx_ff;
   assign wr_addr = cmd.clear_wr ? cnt_ff[AW-1:0] : idx_ff;
   assign cell_we = cmd.wr_cell && inside_ff && (op_ff <= OP_DECAY);
   assign we_a    = cmd.clear_wr || (cell_we && !bank_sel_ff);
   assign we_b    = cmd.clear_wr || (cell_we && bank_sel_ff);
   assign wr_data = cmd.clear_wr ? '0 : {new_ty, new_lv};

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_a[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_b_ff <= mem_b[rd_addr];
      end
   end

   assign cur_word  = bank_sel_ff ? rd_b_ff : rd_a_ff;
   assign prev_word = bank_sel_ff ? rd_a_ff : rd_b_ff;
   assign cur_lv    = cur_word[BYTE_W-1:0];
   assign cur_ty    = cur_word[WORD_W-1:BYTE_W];
   assign add_sum   = {1'b0, cur_lv} + {1'b0, val_ff};

   // Set, saturating add and decay of one cell.
   always_comb begin
      new_lv = cur_lv;
      new_ty = cur_ty;
      case (op_ff)
         OP_SET: begin
            new_lv = val_ff;
         end
         OP_ADD: begin
            new_lv = add_sum[BYTE_W] ? LEVEL_MAX : add_sum[BYTE_W-1:0];
            if ((cur_ty == '0) || (val_ff != '0)) begin
               new_ty = kind_ff;
            end
         end
         OP_DECAY: begin
            if (cur_lv <= val_ff) begin
               new_lv = '0;
               new_ty = '0;
            end else begin
               new_lv = cur_lv - val_ff;
            end
         end
         default: begin
            new_lv = cur_lv;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_sel_ff <= 1'b0;
      end else if (cmd.swap) begin
         bank_sel_ff <= !bank_sel_ff;
      end
   end

   // Scan accumulation happens in the cycle after the read.
   assign thresh = (op_ff == OP_STATS) ? TOXIC_LEVEL : val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pend_ff <= 1'b0;
      end else begin
         scan_pend_ff <= cmd.rd_scan;
      end
      if (cmd.acc_clear) begin
         acc_sum_ff <= '0;
         acc_cnt_ff <= '0;
      end else if (scan_pend_ff) begin
         acc_sum_ff <= acc_sum_ff + TOTAL_W'(cur_lv);
         acc_cnt_ff <= acc_cnt_ff + COUNT_W'(cur_lv >= thresh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.stat_zero) begin
         stat_total_ff <= '0;
         stat_toxic_ff <= '0;
      end else if (cmd.stat_commit && (op_ff == OP_STATS)) begin
         stat_total_ff <= acc_sum_ff;
         stat_toxic_ff <= acc_cnt_ff;
      end
   end

   // Result word.
   assign is_read   = (op_ff == OP_READ_CUR) || (op_ff == OP_READ_PREV);
   assign res_range = (op_ff <= OP_READ_PREV) && inside_ff;

   always_comb begin
      res_level = '0;
      res_kind  = '0;
      if (is_read && inside_ff) begin
         if (op_ff == OP_READ_CUR) begin
            res_level = cur_word[BYTE_W-1:0];
            res_kind  = cur_word[WORD_W-1:BYTE_W];
         end else begin
            res_level = prev_word[BYTE_W-1:0];
            res_kind  = prev_word[WORD_W-1:BYTE_W];
         end
      end
      res_total = (op_ff == OP_STATS) ? acc_sum_ff : stat_total_ff;
      if ((op_ff == OP_STATS) || (op_ff == OP_THRESH)) begin
         res_count = acc_cnt_ff;
      end else begin
         res_count = stat_toxic_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (cmd.out_load) begin
         out_level_ff <= res_level;
         out_kind_ff  <= res_kind;
         out_range_ff <= res_range;
         out_total_ff <= res_total;
         out_count_ff <= res_count;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_level    = out_level_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_in_range = out_range_ff;
   assign rsp_total    = out_total_ff;
   assign rsp_count    = out_count_ff;

   assign sts.op         = op_ff;
   assign sts.scan_end   = (cnt_ff == ncells_ff);
   assign sts.sweep_last = (cnt_ff == CNT_W'(CELLS - 1));
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   // Scan reads stay inside the cell count registered for this item.
   assert property (@(posedge clock) disable iff (reset) cmd.rd_scan |-> cnt_ff < ncells_ff)
      else $error("scan address beyond the grid in use");

   // Cell data only ever leaves the block together with in_range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_level != '0) || (rsp_kind != '0))) |-> rsp_in_range)
      else $error("cell data returned for a coordinate outside the grid");

   // A pending scan word must not be overwritten by a cell read.
   assert property (@(posedge clock) disable iff (reset) scan_pend_ff |-> !cmd.rd_cell)
      else $error("cell read collides with a scan read");

endmodule

@@ rtl/core/double_buffered_level_grid.sv @@
// Top level of the double-buffered level grid: stream ports, configuration
// registers, and the controller and datapath. Depends on dblg_pkg,
// dblg_ctrl and dblg_datapath.
//
//   Channel   Direction  Handshake                 Contents
//   req_*     in         tvalid/tready             one operation word
//   rsp_*     out        tvalid/tready             one result word per operation
//   csr_*     in/out     psel/penable/pready       grid_width (0x0), grid_height (0x4)
//
// A cell operation (set, add, decay, read) steps from accept to the next accept through
// latch, address multiply, bank read, modify/write and result load. Swap and undefined
// opcodes skip the bank read and modify/write. The stats and threshold scans read
// one cell per cycle through the current bank's read port, and clear sweeps both
// banks one word per cycle.
// After reset a clearing pass over all MAX_COLS*MAX_ROWS words zeroes both banks;
// req_tready stays low during it, while configuration writes are taken.
// The result register decouples the sides: a word accepted while a result
// still waits runs until its own result is ready, then holds until rsp_tready.
module double_buffered_level_grid
   import dblg_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // col [15:0], row [31:16], value [39:32], kind [47:40]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // opcode [3:0]
   input  logic [OP_W-1:0]         req_tuser,
   // Result channel.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // level_out [7:0], kind_out [15:8], total_level [35:16], cell_count [48:36],
   // zero fill [55:49]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // in_range [0]
   output logic                    rsp_tuser,
   // Configuration port.
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   dblg_cmd_type cmd;
   dblg_sts_type sts;

   logic [GRID_W-1:0]  grid_width_ff, grid_width_in;
   logic [GRID_W-1:0]  grid_height_ff, grid_height_in;
   logic               csr_wr;
   logic               csr_sel;
   logic [BYTE_W-1:0]  rsp_level, rsp_kind;
   logic [TOTAL_W-1:0] rsp_total;
   logic [COUNT_W-1:0] rsp_count;

   // Registers sit on word addresses; bit 2 picks the register and the
   // byte-offset bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            CSR_GRID_WIDTH:  grid_width_in  = csr_pwdata[GRID_W-1:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_pwdata[GRID_W-1:0];
            default:         grid_width_in  = grid_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_RESET;
         grid_height_ff <= GRID_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_GRID_WIDTH:  csr_prdata = CSR_DATA_W'(grid_width_ff);
         CSR_GRID_HEIGHT: csr_prdata = CSR_DATA_W'(grid_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   dblg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dblg_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_tuser),
      .req_col      (req_tdata[15:0]),
      .req_row      (req_tdata[31:16]),
      .req_value    (req_tdata[39:32]),
      .req_kind     (req_tdata[47:40]),
      .grid_width   (grid_width_ff),
      .grid_height  (grid_height_ff),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_level    (rsp_level),
      .rsp_kind     (rsp_kind),
      .rsp_in_range (rsp_tuser),
      .rsp_total    (rsp_total),
      .rsp_count    (rsp_count)
   );

   // Pack the result word, first field in the lowest bits.
   assign rsp_tdata = {7'd0, rsp_count, rsp_total, rsp_kind, rsp_level};

endmodule

@@ dv/double_buffered_level_grid_test.sv @@
// Self-checking testbench for double_buffered_level_grid: random and directed grid operations,
// each result compared with an in-testbench model of both cell banks and the held statistics.
// Depends on dblg_pkg and the double_buffered_level_grid RTL only.
module double_buffered_level_grid_test
   import dblg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_COLS = DEF_MAX_COLS;
   localparam int GRID_ROWS = DEF_MAX_ROWS;
   localparam int CELLS = GRID_COLS * GRID_ROWS;

   // A clear sweeps every word of a bank, and the clearing pass after reset does the same.
   // The slowest correct stretch without a handshake is well below this.
   localparam int QUIET_LIMIT = 20000;

   // Grid sizes are programmed per phase. The list includes zero, the largest size and
   // sizes above the largest, and it moves between sizes without clearing the banks.
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 40;
   localparam int PHASE_COLS [0:PHASE_COUNT-1] = '{8, 1, 0, 5, 127, 3, 16, 1, 64, 100, 12, 64};
   localparam int PHASE_ROWS [0:PHASE_COUNT-1] = '{8, 1, 5, 0, 3, 127, 4, 64, 1, 100, 20, 64};

   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR  = {CSR_GRID_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] HEIGHT_ADDR = {CSR_GRID_HEIGHT, 2'b00};

   // One operation as it travels on the request channel.
   typedef struct {
      logic [OP_W-1:0]           op;
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      logic [BYTE_W-1:0]         value;
      logic [BYTE_W-1:0]         kind;
   } grid_op_type;

   // One result word, unpacked.
   typedef struct {
      logic [BYTE_W-1:0]  level;
      logic [BYTE_W-1:0]  kind;
      logic               in_range;
      logic [TOTAL_W-1:0] total;
      logic [COUNT_W-1:0] tally;
   } grid_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // col [15:0], row [31:16], value [39:32], kind [47:40]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // opcode [3:0]
   logic [OP_W-1:0]       req_tuser = '0;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // level_out [7:0], kind_out [15:8], total_level [35:16], cell_count [48:36]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // in_range [0]
   logic                  rsp_tuser;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   double_buffered_level_grid #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Operations waiting to be sent, and results owed by the block, oldest first.
   grid_op_type     pending_ops[$];
   grid_result_type owed_results[$];

   // Model state: both banks as flat word arrays (type in the upper byte, level in the
   // lower), the bank that is current, the held statistics and the size registers.
   logic [2*BYTE_W-1:0] cell_word [0:1][0:CELLS-1];
   bit                  current_bank;
   logic [TOTAL_W-1:0]  held_total;
   logic [COUNT_W-1:0]  held_toxic;
   logic [GRID_W-1:0]   grid_width_reg;
   logic [GRID_W-1:0]   grid_height_reg;

   int fail_count;
   int ops_done;
   int sweeps_done;
   int off_grid_ops;

   // Flow control state for the two stream sides.
   int req_gap;
   bit req_burst;
   int rsp_stall;
   bit rsp_burst;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Wait length for the next word on one side. A side flips now and then into a mode
   // with no waiting at all, so that back-to-back stretches occur as well.
   function automatic int draw_wait(inout bit burst);
      if ($urandom_range(0, 24) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(0, 16);
   endfunction

   // Applies one accepted operation to the model and returns the result word it owes.
   function automatic grid_result_type apply_grid_op(grid_op_type item);
      grid_result_type   res;
      int                cols;
      int                rows;
      int                ncells;
      int                c;
      int                r;
      int                idx;
      int                hits;
      bit                on_grid;
      logic [15:0]       word;
      logic [BYTE_W:0]   sum;
      logic [BYTE_W-1:0] ty;

      res = '{default: '0};
      cols = (grid_width_reg > GRID_COLS) ? GRID_COLS : grid_width_reg;
      rows = (grid_height_reg > GRID_ROWS) ? GRID_ROWS : grid_height_reg;
      ncells = cols * rows;
      c = item.col;
      r = item.row;
      on_grid = (c >= 0) && (r >= 0) && (c < cols) && (r < rows);
      idx = on_grid ? r * cols + c : 0;
      word = cell_word[current_bank][idx];
      hits = 0;
      ops_done++;

      if (item.op <= OP_READ_PREV) begin
         res.in_range = on_grid;
         if (!on_grid)
            off_grid_ops++;
      end

      case (item.op)
         OP_SET: begin
            if (on_grid)
               cell_word[current_bank][idx] = {word[15:8], item.value};
         end
         OP_ADD: begin
            if (on_grid) begin
               sum = word[7:0] + item.value;
               ty = (word[15:8] == '0 || item.value != '0) ? item.kind : word[15:8];
               cell_word[current_bank][idx] = {ty, sum[BYTE_W] ? LEVEL_MAX : sum[7:0]};
            end
         end
         OP_DECAY: begin
            // A level that would reach zero takes the type with it.
            if (on_grid) begin
               if (word[7:0] <= item.value)
                  cell_word[current_bank][idx] = '0;
               else
                  cell_word[current_bank][idx] = {word[15:8], word[7:0] - item.value};
            end
         end
         OP_READ_CUR, OP_READ_PREV: begin
            if (on_grid) begin
               if (item.op == OP_READ_PREV)
                  word = cell_word[!current_bank][idx];
               res.level = word[7:0];
               res.kind = word[15:8];
            end
         end
         OP_SWAP: begin
            current_bank = !current_bank;
         end
         OP_STATS: begin
            sweeps_done++;
            held_total = '0;
            held_toxic = '0;
            for (int i = 0; i < ncells; i++) begin
               held_total += cell_word[current_bank][i][7:0];
               if (cell_word[current_bank][i][7:0] >= TOXIC_LEVEL)
                  held_toxic++;
            end
         end
         OP_THRESH: begin
            sweeps_done++;
            for (int i = 0; i < ncells; i++)
               if (cell_word[current_bank][i][7:0] >= item.value)
                  hits++;
         end
         OP_CLEAR: begin
            sweeps_done++;
            for (int i = 0; i < CELLS; i++) begin
               cell_word[0][i] = '0;
               cell_word[1][i] = '0;
            end
            held_total = '0;
            held_toxic = '0;
         end
         default: begin
            // Undefined opcodes leave everything alone and report the held statistics.
         end
      endcase

      res.total = held_total;
      res.tally = (item.op == OP_THRESH) ? COUNT_W'(hits) : held_toxic;
      return res;
   endfunction

   function automatic grid_op_type make_op(logic [OP_W-1:0] op, int col, int row,
                                           int value, int kind);
      grid_op_type item;
      item.op = op;
      item.col = COORD_W'(col);
      item.row = COORD_W'(row);
      item.value = BYTE_W'(value);
      item.kind = BYTE_W'(kind);
      return item;
   endfunction

   // Random operation for a grid of the given effective size. Cell operations dominate and
   // often hit a small corner so that later reads and scans see earlier writes; sweeps are
   // rarer on big grids since each one reads or clears every cell in turn.
   function automatic grid_op_type random_grid_op(int cols, int rows);
      grid_op_type item;
      int          pick;

      pick = $urandom_range(0, 999);
      if (pick < 220)
         item.op = OP_SET;
      else if (pick < 440)
         item.op = OP_ADD;
      else if (pick < 600)
         item.op = OP_DECAY;
      else if (pick < 720)
         item.op = OP_READ_CUR;
      else if (pick < 800)
         item.op = OP_READ_PREV;
      else if (pick < 850)
         item.op = OP_SWAP;
      else if (pick < 930)
         item.op = (cols * rows > 256 && pick >= 870) ? OP_READ_CUR :
                   (pick[0] ? OP_STATS : OP_THRESH);
      else if (pick < 950)
         item.op = OP_CLEAR;
      else
         item.op = OP_W'($urandom_range(OP_CLEAR + 1, 15));

      if (cols > 0 && rows > 0 && $urandom_range(0, 99) < 85) begin
         if ($urandom_range(0, 1) == 1) begin
            item.col = COORD_W'($urandom_range(0, (cols < 4 ? cols : 4) - 1));
            item.row = COORD_W'($urandom_range(0, (rows < 4 ? rows : 4) - 1));
         end else begin
            item.col = COORD_W'($urandom_range(0, cols - 1));
            item.row = COORD_W'($urandom_range(0, rows - 1));
         end
      end else begin
         // Off the grid: just past an edge, slightly negative, or anywhere at all.
         item.col = COORD_W'($urandom_range(0, 3));
         item.row = COORD_W'($urandom_range(0, 3));
         case ($urandom_range(0, 4))
            0: item.col = -COORD_W'($urandom_range(1, 4));
            1: item.col = COORD_W'(cols);
            2: item.row = COORD_W'(rows);
            3: begin
               item.col = COORD_W'($urandom);
               item.row = COORD_W'($urandom);
            end
            default: begin
               item.col = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               item.row = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
         endcase
      end

      case ($urandom_range(0, 9))
         0: item.value = '0;
         1: item.value = '1;
         default: item.value = BYTE_W'($urandom);
      endcase
      item.kind = ($urandom_range(0, 4) == 0) ? '0 : BYTE_W'($urandom);
      return item;
   endfunction

   // Request driver. A word is presented once its wait has run out and holds until taken.
   // The model is updated at the edge where the block takes the word.
   always @(posedge clock) begin
      grid_op_type req_in_flight;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            owed_results.push_back(apply_grid_op(req_in_flight));
            req_gap = draw_wait(req_burst);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               req_in_flight = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= req_in_flight.op;
               req_tdata <= {req_in_flight.kind, req_in_flight.value,
                             req_in_flight.row, req_in_flight.col};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   // Result monitor. Every word taken is checked against the oldest owed result, and the
   // ready line then stalls for a freshly drawn wait.
   always @(posedge clock) begin
      grid_result_type owed;
      if (reset) begin
         rsp_stall = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               $error("result word arrived with no operation outstanding");
               fail_count++;
            end else begin
               owed = owed_results.pop_front();
               check_field("level_out", owed.level, rsp_tdata[7:0]);
               check_field("kind_out", owed.kind, rsp_tdata[15:8]);
               check_field("in_range", owed.in_range, rsp_tuser);
               check_field("total_level", owed.total, rsp_tdata[35:16]);
               check_field("cell_count", owed.tally, rsp_tdata[48:36]);
            end
            rsp_stall = draw_wait(rsp_burst);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // Watchdog: any handshake on either stream or the configuration port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("No handshake for %0d cycles, giving up.", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Register write: a setup phase, then an access phase that ends on an edge with pready
   // high. The upper data bits are random, since only the low seven bits are kept.
   task automatic write_size_reg(logic [CSR_ADDR_W-1:0] addr, int size);
      logic [CSR_DATA_W-1:0] data;
      data = ($urandom & ~CSR_DATA_W'(7'h7F)) | CSR_DATA_W'(size);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == WIDTH_ADDR)
         grid_width_reg = data[GRID_W-1:0];
      else
         grid_height_reg = data[GRID_W-1:0];
   endtask

   // Waits until every queued operation has been sent and answered. Each operation yields
   // exactly one result, so the block is idle once the last one is in. The queues and the
   // valid line are looked at on the falling edge, after the rising edge has settled.
   task automatic wait_for_drain();
      while (pending_ops.size() != 0 || req_tvalid || owed_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int cols;
      int rows;

      for (int i = 0; i < CELLS; i++) begin
         cell_word[0][i] = '0;
         cell_word[1][i] = '0;
      end
      current_bank = 1'b0;
      held_total = '0;
      held_toxic = '0;
      grid_width_reg = GRID_RESET;
      grid_height_reg = GRID_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the full 64 by 64 grid that reset leaves behind: corners,
      // saturation, type adoption rules, decay to zero, coordinates just off each edge and
      // at the extremes, both reads across a swap, the sweeps, undefined opcodes and clear.
      pending_ops.push_back(make_op(OP_READ_CUR, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_SET, 0, 0, 255, 255));
      pending_ops.push_back(make_op(OP_SET, 63, 63, 128, 0));
      pending_ops.push_back(make_op(OP_ADD, 63, 63, 200, 8'hA5));
      pending_ops.push_back(make_op(OP_ADD, 63, 63, 0, 8'h5A));
      pending_ops.push_back(make_op(OP_ADD, 0, 0, 0, 8'h3C));
      pending_ops.push_back(make_op(OP_DECAY, 0, 0, 10, 0));
      pending_ops.push_back(make_op(OP_ADD, 5, 7, 255, 255));
      pending_ops.push_back(make_op(OP_DECAY, 63, 63, 255, 0));
      pending_ops.push_back(make_op(OP_SET, -1, 0, 77, 0));
      pending_ops.push_back(make_op(OP_ADD, 64, 5, 9, 1));
      pending_ops.push_back(make_op(OP_DECAY, 3, -1, 1, 0));
      pending_ops.push_back(make_op(OP_READ_CUR, 0, 64, 0, 0));
      pending_ops.push_back(make_op(OP_READ_PREV, -32768, 32767, 255, 255));
      pending_ops.push_back(make_op(OP_READ_CUR, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_STATS, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_THRESH, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_THRESH, -1, -1, 255, 255));
      pending_ops.push_back(make_op(OP_SWAP, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_READ_PREV, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_READ_CUR, 0, 0, 0, 0));
      pending_ops.push_back(make_op(4'd15, 0, 0, 255, 255));
      pending_ops.push_back(make_op(4'd9, 1, 1, 0, 0));
      pending_ops.push_back(make_op(OP_CLEAR, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_READ_PREV, 0, 0, 0, 0));
      wait_for_drain();

      // Random phases, one grid size each. The banks are not cleared in between, so cells
      // written under one width show up at new positions under the next.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_size_reg(WIDTH_ADDR, PHASE_COLS[p]);
         write_size_reg(HEIGHT_ADDR, PHASE_ROWS[p]);
         cols = (PHASE_COLS[p] > GRID_COLS) ? GRID_COLS : PHASE_COLS[p];
         rows = (PHASE_ROWS[p] > GRID_ROWS) ? GRID_ROWS : PHASE_ROWS[p];
         for (int n = 0; n < PHASE_ITEMS; n++)
            pending_ops.push_back(random_grid_op(cols, rows));
         wait_for_drain();
      end

      // Give a stray extra result word time to show up before the verdict.
      repeat (20) @(posedge clock);

      $display("Checked %0d operations over %0d grid sizes, with %0d sweeps or clears",
               ops_done, PHASE_COUNT + 1, sweeps_done);
      $display("and %0d cell accesses that fell outside the grid.", off_grid_ops);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
